// ----- rtl/core/arr_pkg.sv -----
// ----------------------------------------------------------------------------
// arr_pkg
// shared widths, types and saturation helpers for the rectangle hit pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package arr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  localparam int NUM_W     = W + 1 + FRAC_BITS;
  localparam int PW        = 2 * W - FRAC_BITS;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_AXIS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COORD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HI    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_LO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HI   = 3'd5;

  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic signed [W-1:0] ox;
    logic signed [W-1:0] oy;
    logic signed [W-1:0] oz;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] dz;
    logic signed [W-1:0] tlo;
    logic signed [W-1:0] thi;
    logic                miss;
    logic                neg;
    logic                front;
  } ray_t;

  function automatic logic signed [W-1:0] sat_prod(input logic signed [PW-1:0] x);
    logic all_same;
    all_same = (x[PW-1:W-1] == '0) || (x[PW-1:W-1] == '1);
    if (all_same) return x[W-1:0];
    return x[PW-1] ? SMIN : SMAX;
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] x);
    if (x[W] == x[W-1]) return x[W-1:0];
    return x[W] ? SMIN : SMAX;
  endfunction

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] x);
    if (x == SMIN) return SMAX;
    return -x;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/arr_front.sv -----
// ----------------------------------------------------------------------------
// arr_front
// input stage: picks the normal axis and forms divider operands
// ----------------------------------------------------------------------------
`default_nettype none

module arr_front import arr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [W-1:0] origin_x,
  input  wire logic signed [W-1:0] origin_y,
  input  wire logic signed [W-1:0] origin_z,
  input  wire logic signed [W-1:0] dir_x,
  input  wire logic signed [W-1:0] dir_y,
  input  wire logic signed [W-1:0] dir_z,
  input  wire logic signed [W-1:0] t_lo,
  input  wire logic signed [W-1:0] t_hi,
  input  wire logic [1:0]          plane_axis,
  input  wire logic signed [W-1:0] plane_coord,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ray_t                     ray,
  output logic [NUM_W-1:0]         num,
  output logic [W-1:0]             den
);

  logic signed [W-1:0] org_a;
  logic signed [W-1:0] dir_a;
  logic signed [W:0]   diff;
  logic [W:0]          diff_mag;
  logic [W-1:0]        dir_mag;
  logic                en;

  always_comb begin
    case (plane_axis)
      AXIS_X: begin org_a = origin_x; dir_a = dir_x; end
      AXIS_Y: begin org_a = origin_y; dir_a = dir_y; end
      default: begin org_a = origin_z; dir_a = dir_z; end
    endcase
    diff     = {plane_coord[W-1], plane_coord} - {org_a[W-1], org_a};
    diff_mag = diff[W] ? (W+1)'(-diff) : diff;
    dir_mag  = dir_a[W-1] ? W'(-dir_a) : dir_a;
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray.ox    <= origin_x;
      ray.oy    <= origin_y;
      ray.oz    <= origin_z;
      ray.dx    <= dir_x;
      ray.dy    <= dir_y;
      ray.dz    <= dir_z;
      ray.tlo   <= t_lo;
      ray.thi   <= t_hi;
      ray.miss  <= (plane_axis != AXIS_X && plane_axis != AXIS_Y && plane_axis != AXIS_Z)
                   || (dir_a == '0);
      ray.neg   <= diff[W] ^ dir_a[W-1];
      ray.front <= dir_a[W-1];
      num       <= {diff_mag, {FRAC_BITS{1'b0}}};
      den       <= dir_mag;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/arr_div.sv -----
// ----------------------------------------------------------------------------
// arr_div
// restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none

module arr_div import arr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ray_t             in_ray,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [W-1:0]     in_den,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ray_t                  out_ray,
  output logic [NUM_W-1:0]      quot
);

  logic             v    [NUM_W];
  logic [W-1:0]     rem  [NUM_W];
  logic [NUM_W-1:0] q    [NUM_W];
  logic [NUM_W-1:0] nm   [NUM_W];
  logic [W-1:0]     dn   [NUM_W];
  ray_t             rr   [NUM_W];
  wire  [NUM_W-1:0] en;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             p_v;
    logic [W-1:0]     p_rem;
    logic [NUM_W-1:0] p_q;
    logic [NUM_W-1:0] p_num;
    logic [W-1:0]     p_den;
    ray_t             p_ray;
    logic             nxt_en;
    logic [W:0]       r2;
    logic             ge;

    if (k == 0) begin : g_first
      assign p_v   = in_valid;
      assign p_rem = '0;
      assign p_q   = '0;
      assign p_num = in_num;
      assign p_den = in_den;
      assign p_ray = in_ray;
    end else begin : g_rest
      assign p_v   = v[k-1];
      assign p_rem = rem[k-1];
      assign p_q   = q[k-1];
      assign p_num = nm[k-1];
      assign p_den = dn[k-1];
      assign p_ray = rr[k-1];
    end

    if (k == NUM_W - 1) begin : g_last
      assign nxt_en = out_ready;
    end else begin : g_mid
      assign nxt_en = en[k+1];
    end

    assign en[k] = !v[k] || nxt_en;
    assign r2    = {p_rem, p_num[NUM_W-1-k]};
    assign ge    = r2 >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? W'(r2 - {1'b0, p_den}) : r2[W-1:0];
        q[k]   <= {p_q[NUM_W-2:0], ge};
        nm[k]  <= p_num;
        dn[k]  <= p_den;
        rr[k]  <= p_ray;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NUM_W-1];
  assign out_ray   = rr[NUM_W-1];
  assign quot      = q[NUM_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/arr_back.sv -----
// ----------------------------------------------------------------------------
// arr_back
// t saturation and window, point products, point sums, bounds and texture
// ----------------------------------------------------------------------------
`default_nettype none

module arr_back import arr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ray_t                in_ray,
  input  wire logic [NUM_W-1:0]    quot,
  input  wire logic [1:0]          plane_axis,
  input  wire logic signed [W-1:0] first_lo,
  input  wire logic signed [W-1:0] first_hi,
  input  wire logic signed [W-1:0] second_lo,
  input  wire logic signed [W-1:0] second_hi,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     hit,
  output logic signed [W-1:0]      hit_t,
  output logic signed [W-1:0]      point_x,
  output logic signed [W-1:0]      point_y,
  output logic signed [W-1:0]      point_z,
  output logic                     front_face,
  output logic signed [W-1:0]      tex_u,
  output logic signed [W-1:0]      tex_v
);

  logic en1, en2, en3, en4;
  logic v1, v2, v3;

  // stage 1: saturate quotient, window test
  logic signed [W-1:0] t0;
  logic [NUM_W-W:0]    q_hi;
  logic signed [W-1:0] t1;
  ray_t                r1;
  logic                m1;

  assign q_hi = quot[NUM_W-1:W-1];

  always_comb begin
    if (!in_ray.neg) begin
      t0 = (q_hi != '0) ? SMAX : quot[W-1:0];
    end else if (q_hi == '0 || (q_hi == (NUM_W-W+1)'(1) && quot[W-2:0] == '0)) begin
      t0 = W'(-quot[W-1:0]);
    end else begin
      t0 = SMIN;
    end
  end

  assign en4 = !out_valid || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      t1 <= t0;
      r1 <= in_ray;
      m1 <= in_ray.miss || (t0 < in_ray.tlo) || (t0 > in_ray.thi);
    end
  end

  // stage 2: products
  logic signed [2*W-1:0] px2, py2, pz2;
  logic signed [W-1:0]   t2;
  ray_t                  r2;
  logic                  m2;

  always_ff @(posedge clk) begin
    if (en2) begin
      px2 <= t1 * r1.dx;
      py2 <= t1 * r1.dy;
      pz2 <= t1 * r1.dz;
      t2  <= t1;
      r2  <= r1;
      m2  <= m1;
    end
  end

  // stage 3: floor shift and origin add
  logic signed [W-1:0] ptx, pty, ptz, t3;
  logic signed [W-1:0] sx, sy, sz;
  logic                m3, f3;

  assign sx = sat_prod(px2[2*W-1:FRAC_BITS]);
  assign sy = sat_prod(py2[2*W-1:FRAC_BITS]);
  assign sz = sat_prod(pz2[2*W-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en3) begin
      ptx <= sat_sum({r2.ox[W-1], r2.ox} + {sx[W-1], sx});
      pty <= sat_sum({r2.oy[W-1], r2.oy} + {sy[W-1], sy});
      ptz <= sat_sum({r2.oz[W-1], r2.oz} + {sz[W-1], sz});
      t3  <= t2;
      m3  <= m2;
      f3  <= r2.front;
    end
  end

  // stage 4: bounds, texture, output register
  logic signed [W-1:0] c1, c2, u4, v4;
  logic                in_box;

  always_comb begin
    case (plane_axis)
      AXIS_X: begin
        c1 = pty; c2 = ptz; u4 = ptz; v4 = neg_sat(pty);
      end
      AXIS_Y: begin
        c1 = ptx; c2 = ptz; u4 = neg_sat(ptz); v4 = neg_sat(ptx);
      end
      default: begin
        c1 = ptx; c2 = pty; u4 = pty; v4 = neg_sat(ptx);
      end
    endcase
    in_box = !m3 && c1 >= first_lo && c1 <= first_hi && c2 >= second_lo && c2 <= second_hi;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      hit        <= in_box;
      hit_t      <= in_box ? t3 : '0;
      point_x    <= in_box ? ptx : '0;
      point_y    <= in_box ? pty : '0;
      point_z    <= in_box ? ptz : '0;
      front_face <= in_box && f3;
      tex_u      <= in_box ? u4 : '0;
      tex_v      <= in_box ? v4 : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/axis_aligned_rectangle_ray_hit.sv -----
// ----------------------------------------------------------------------------
// axis_aligned_rectangle_ray_hit
// ray against one configured axis-aligned rectangle, signed Q16.16
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  input   | in_valid / in_ready      | origin_*, dir_*, t_lo, t_hi
//  output  | out_valid / out_ready    | hit, hit_t, point_*, front_face, tex_*
//  config  | cfg_we                   | cfg_index, cfg_data
//
//  one ray per cycle while the output is not stalled; input stage, 49 divider stages
//  (one quotient bit each), then window, product, sum and output stages
//  every stage holds its own valid bit, so bubbles collapse under a stall
//  synchronous reset clears valid bits and restores the config registers
// ----------------------------------------------------------------------------
`default_nettype none

module axis_aligned_rectangle_ray_hit import arr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [W-1:0]         cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [W-1:0]  origin_x,
  input  wire logic signed [W-1:0]  origin_y,
  input  wire logic signed [W-1:0]  origin_z,
  input  wire logic signed [W-1:0]  dir_x,
  input  wire logic signed [W-1:0]  dir_y,
  input  wire logic signed [W-1:0]  dir_z,
  input  wire logic signed [W-1:0]  t_lo,
  input  wire logic signed [W-1:0]  t_hi,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      hit,
  output logic signed [W-1:0]       hit_t,
  output logic signed [W-1:0]       point_x,
  output logic signed [W-1:0]       point_y,
  output logic signed [W-1:0]       point_z,
  output logic                      front_face,
  output logic signed [W-1:0]       tex_u,
  output logic signed [W-1:0]       tex_v
);

  logic [1:0]          plane_axis;
  logic signed [W-1:0] plane_coord, first_lo, first_hi, second_lo, second_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_axis  <= AXIS_Z;
      plane_coord <= '0;
      first_lo    <= '0;
      first_hi    <= '0;
      second_lo   <= '0;
      second_hi   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLANE_AXIS:  plane_axis  <= cfg_data[1:0];
        REG_PLANE_COORD: plane_coord <= cfg_data;
        REG_FIRST_LO:    first_lo    <= cfg_data;
        REG_FIRST_HI:    first_hi    <= cfg_data;
        REG_SECOND_LO:   second_lo   <= cfg_data;
        REG_SECOND_HI:   second_hi   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             f_valid, f_ready, d_valid, d_ready;
  ray_t             f_ray, d_ray;
  logic [NUM_W-1:0] f_num, d_quot;
  logic [W-1:0]     f_den;

  arr_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z, .t_lo, .t_hi,
    .plane_axis, .plane_coord,
    .out_valid (f_valid), .out_ready (f_ready),
    .ray (f_ray), .num (f_num), .den (f_den)
  );

  arr_div u_div (
    .clk, .rst,
    .in_valid (f_valid), .in_ready (f_ready),
    .in_ray (f_ray), .in_num (f_num), .in_den (f_den),
    .out_valid (d_valid), .out_ready (d_ready),
    .out_ray (d_ray), .quot (d_quot)
  );

  arr_back u_back (
    .clk, .rst,
    .in_valid (d_valid), .in_ready (d_ready),
    .in_ray (d_ray), .quot (d_quot),
    .plane_axis, .first_lo, .first_hi, .second_lo, .second_hi,
    .out_valid, .out_ready,
    .hit, .hit_t, .point_x, .point_y, .point_z, .front_face, .tex_u, .tex_v
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_t == '0 && tex_u == '0 && tex_v == '0 && !front_face)
    else $error("miss result carries nonzero fields");

  a_hit_bounds_z: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit && plane_axis == AXIS_Z |->
      point_x >= first_lo && point_x <= first_hi &&
      point_y >= second_lo && point_y <= second_hi)
    else $error("hit point outside rectangle");

  a_stall_flows: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> d_ready)
    else $error("back end stalled while output drains");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the ray against axis-aligned rectangle hit pipeline
// ----------------------------------------------------------------------------
// a directed table of rays runs under the reset setup, then random phases,
// each with a fresh rectangle setup, mix rays aimed into the rectangle with
// fully random rays. every accepted ray is predicted in fixed point and the
// results are compared in order, field by field. both sides idle at random,
// and one phase holds the output off long enough to back the pipeline up.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import arr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [W-1:0] ox, oy, oz, dx, dy, dz, tlo, thi;
  } ray_in_t;

  typedef struct packed {
    logic                hit;
    logic signed [W-1:0] t, px, py, pz;
    logic                ff;
    logic signed [W-1:0] u, v;
  } hit_rec_t;

  typedef struct packed {
    ray_in_t r;
    logic    known_miss;
  } table_row_t;

  localparam int ONE = 1 << FRAC_BITS;
  localparam int NUM_PHASES = 12;
  localparam int RAYS_PER_PHASE = 130;
  localparam int DRAIN_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [W-1:0] t_lo = '0, t_hi = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit, front_face;
  logic signed [W-1:0] hit_t, point_x, point_y, point_z, tex_u, tex_v;

  axis_aligned_rectangle_ray_hit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // rectangle setup as the pipeline holds it
  logic [1:0] cur_axis = AXIS_Z;
  logic signed [W-1:0] cur_coord = '0;
  logic signed [W-1:0] cur_bound [6];

  hit_rec_t pending_hits [$];
  int errors = 0;
  int rays_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic longint clamp32(longint x);
    if (x > longint'(SMAX)) return longint'(SMAX);
    if (x < longint'(SMIN)) return longint'(SMIN);
    return x;
  endfunction

  function automatic hit_rec_t predict_hit(ray_in_t r);
    longint o [3], d [3], p [3];
    longint num, t, c1, c2;
    int a, i1, i2;
    hit_rec_t res;
    res = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    if (cur_axis > AXIS_Z) return res;
    a = cur_axis;
    if (d[a] == 0) return res;
    num = (longint'(cur_coord) - o[a]) * (longint'(1) << FRAC_BITS);
    t = clamp32(num / d[a]);
    if (t < longint'(r.tlo) || t > longint'(r.thi)) return res;
    for (int k = 0; k < 3; k++)
      p[k] = clamp32(o[k] + clamp32((t * d[k]) >>> FRAC_BITS));
    i1 = (a == 0) ? 1 : 0;
    i2 = (a == 2) ? 1 : 2;
    c1 = p[i1];
    c2 = p[i2];
    if (c1 < longint'(cur_bound[REG_FIRST_LO]) || c1 > longint'(cur_bound[REG_FIRST_HI]) ||
        c2 < longint'(cur_bound[REG_SECOND_LO]) || c2 > longint'(cur_bound[REG_SECOND_HI]))
      return res;
    res.hit = 1'b1;
    res.t = t[W-1:0];
    res.px = p[0][W-1:0];
    res.py = p[1][W-1:0];
    res.pz = p[2][W-1:0];
    res.ff = d[a] < 0;
    if (a == 2) begin
      res.u = p[1][W-1:0];
      res.v = W'(clamp32(-p[0]));
    end else if (a == 1) begin
      res.u = W'(clamp32(-p[2]));
      res.v = W'(clamp32(-p[0]));
    end else begin
      res.u = p[2][W-1:0];
      res.v = W'(clamp32(-p[1]));
    end
    return res;
  endfunction

  task automatic write_setup(logic [1:0] axis, logic signed [W-1:0] coord,
                             logic signed [W-1:0] f_lo, logic signed [W-1:0] f_hi,
                             logic signed [W-1:0] s_lo, logic signed [W-1:0] s_hi);
    logic [W-1:0] vals [6];
    vals[REG_PLANE_AXIS] = {30'd0, axis};
    vals[REG_PLANE_COORD] = coord;
    vals[REG_FIRST_LO] = f_lo;
    vals[REG_FIRST_HI] = f_hi;
    vals[REG_SECOND_LO] = s_lo;
    vals[REG_SECOND_HI] = s_hi;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_axis = axis;
    cur_coord = coord;
    for (int i = REG_FIRST_LO; i <= REG_SECOND_HI; i++) cur_bound[i] = vals[i];
  endtask

  task automatic send_ray(ray_in_t r, bit known_miss);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lo, t_hi} <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_hits.push_back(known_miss ? hit_rec_t'('0) : predict_hit(r));
    rays_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rnd_span(int mag);
    return $signed($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic ray_in_t aimed_ray;
    longint t, d [3], tgt [3], o [3];
    longint lo, hi;
    ray_in_t r;
    int a;
    a = (cur_axis > AXIS_Z) ? 2 : cur_axis;
    t = $urandom_range(1, 8 * ONE);
    for (int k = 0; k < 3; k++) d[k] = rnd_span(1 << 18);
    if (d[a] == 0) d[a] = ONE;
    tgt[a] = cur_coord;
    for (int k = 0; k < 3; k++) begin
      if (k != a) begin
        lo = cur_bound[(k == 2 || (k == 1 && a == 2)) ? REG_SECOND_LO : REG_FIRST_LO];
        hi = cur_bound[(k == 2 || (k == 1 && a == 2)) ? REG_SECOND_HI : REG_FIRST_HI];
        if (hi >= lo && hi - lo < (longint'(1) << 30))
          tgt[k] = lo + $urandom_range(0, int'(hi - lo));
        else
          tgt[k] = rnd_span(1 << 24);
      end
      o[k] = clamp32(tgt[k] - ((t * d[k]) >>> FRAC_BITS));
    end
    r.ox = o[0][W-1:0]; r.oy = o[1][W-1:0]; r.oz = o[2][W-1:0];
    r.dx = d[0][W-1:0]; r.dy = d[1][W-1:0]; r.dz = d[2][W-1:0];
    r.tlo = ($urandom_range(9) == 0) ? W'(t + 1) : W'(t - $urandom_range(0, ONE));
    r.thi = W'(t + $urandom_range(0, ONE));
    return r;
  endfunction

  task automatic check_result;
    hit_rec_t e;
    if (pending_hits.size() == 0) begin
      $error("result with no ray outstanding");
      errors++;
      return;
    end
    e = pending_hits.pop_front();
    results_seen++;
    if (hit) hits_seen++;
    if (hit !== e.hit) begin
      $error("hit: expected %0d got %0d", e.hit, hit); errors++;
    end
    if (hit_t !== e.t) begin
      $error("hit_t: expected %0d got %0d", e.t, hit_t); errors++;
    end
    if (point_x !== e.px) begin
      $error("point_x: expected %0d got %0d", e.px, point_x); errors++;
    end
    if (point_y !== e.py) begin
      $error("point_y: expected %0d got %0d", e.py, point_y); errors++;
    end
    if (point_z !== e.pz) begin
      $error("point_z: expected %0d got %0d", e.pz, point_z); errors++;
    end
    if (front_face !== e.ff) begin
      $error("front_face: expected %0d got %0d", e.ff, front_face); errors++;
    end
    if (tex_u !== e.u) begin
      $error("tex_u: expected %0d got %0d", e.u, tex_u); errors++;
    end
    if (tex_v !== e.v) begin
      $error("tex_v: expected %0d got %0d", e.v, tex_v); errors++;
    end
  endtask

  // output side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result();
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  table_row_t ray_table [10];

  initial begin
    logic signed [W-1:0] lo1, lo2;
    ray_in_t r;
    for (int i = REG_FIRST_LO; i <= REG_SECOND_HI; i++) cur_bound[i] = '0;
    //                  ox    oy    oz    dx    dy    dz    tlo   thi   known miss
    ray_table[0] = '{'{0, 0, 0, 0, 0, 0, 0, SMAX}, 1'b1};                 // zero divisor
    ray_table[1] = '{'{0, 0, ONE, 0, 0, -ONE, 0, SMAX}, 1'b0};            // front hit
    ray_table[2] = '{'{0, 0, -ONE, 0, 0, ONE, 0, SMAX}, 1'b0};            // back hit
    ray_table[3] = '{'{0, 0, ONE, 0, 0, -ONE, 2 * ONE, SMAX}, 1'b1};      // t below window
    ray_table[4] = '{'{ONE, 0, ONE, 0, 0, -ONE, 0, SMAX}, 1'b1};          // off the rectangle
    ray_table[5] = '{'{0, 0, ONE, 0, 0, -ONE, SMAX, SMIN}, 1'b1};         // empty window
    ray_table[6] = '{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX}, 1'b0};
    ray_table[7] = '{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN}, 1'b0};
    ray_table[8] = '{'{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                       32'h55555555, 32'haaaaaaaa, SMIN, SMAX}, 1'b0};
    ray_table[9] = '{'{0, 0, SMAX, 1, 1, 1, SMIN, SMAX}, 1'b0};           // saturated t

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (ray_table[i]) send_ray(ray_table[i].r, ray_table[i].known_miss);
    drain();

    // unused axis code: every ray misses
    write_setup(2'd3, 0, SMIN, SMAX, SMIN, SMAX);
    for (int i = 0; i < 6; i++) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      send_ray(r, 1'b1);
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lo1 = rnd_span(1 << 20);
      lo2 = rnd_span(1 << 20);
      case (ph)
        1: write_setup(AXIS_Y, SMIN, SMIN, SMAX, SMIN, SMAX);
        2: write_setup(AXIS_X, SMAX, SMIN, SMAX, SMIN, SMAX);
        3: write_setup(AXIS_Z, rnd_span(1 << 20), SMAX, SMIN, lo2, lo2 + ONE);
        5: write_setup(2'd3, rnd_span(1 << 20), lo1, lo1 + ONE, lo2, lo2 + ONE);
        default: write_setup(2'(ph % 3), rnd_span(1 << 20), lo1,
                             lo1 + $urandom_range(0, 1 << 20),
                             lo2, lo2 + $urandom_range(0, 1 << 20));
      endcase
      steady = (ph == 6);
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < RAYS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 70) r = aimed_ray();
        else r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom};
        send_ray(r, 1'b0);
      end
      drain();
    end

    $display("%0d rays over %0d rectangle setups, %0d results checked, %0d hits",
             rays_sent, NUM_PHASES + 2, results_seen, hits_seen);
    if (errors == 0 && pending_hits.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/arr_pkg.sv
rtl/core/arr_front.sv
rtl/core/arr_div.sv
rtl/core/arr_back.sv
rtl/core/axis_aligned_rectangle_ray_hit.sv
sim/testbench.sv
